// ----- src/mspid_pkg.sv -----
// Package for the motor speed PID block: field widths, register map,
// controller state codes and register reset values. No dependencies.
`default_nettype none

package mspid_pkg;

    // Field and port widths
    localparam int FIELD_W            = 16;
    localparam int ERR_W              = 17;
    localparam int CFG_NUM            = 8;
    localparam int CFG_IDX_W          = 3;
    localparam int APB_ADDR_W         = 5;
    localparam int APB_DATA_W         = 32;

    // Default gain fraction (Q8.8) and half width of the stop band
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int STOP_BAND_HALF     = 50;

    // Register map, index = paddr / 4
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP     = 3'd0,
        CFG_KI     = 3'd1,
        CFG_KD     = 3'd2,
        CFG_PMIN   = 3'd3,
        CFG_PMAX   = 3'd4,
        CFG_TARGET = 3'd5,
        CFG_START  = 3'd6,
        CFG_STOP   = 3'd7
    } t_cfg_idx;

    // Controller sequence
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_MUL2DIV,
        ST_SUM,
        ST_ABS,
        ST_CLAMP
    } t_state;

    // Term added to the accumulator in each summing cycle
    typedef enum logic [1:0] {
        TERM_P,
        TERM_D,
        TERM_I
    } t_term;

    function automatic logic [FIELD_W-1:0] cfg_reset(input t_cfg_idx idx);
        logic [FIELD_W-1:0] val;
        case (idx)
            CFG_KP:   val = 16'd256;
            CFG_PMAX: val = 16'd1000;
            CFG_STOP: val = 16'd300;
            default:  val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- src/mspid_if.sv -----
// Valid/ready channel interfaces for the PID block: sensor items in,
// drive commands out. Depends on mspid_pkg.
`default_nettype none

interface mspid_in_if;
    import mspid_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] encoder_count;
    logic        [FIELD_W-1:0] elapsed_ticks;
    logic        [FIELD_W-1:0] distance;

    modport source (output valid, encoder_count, elapsed_ticks, distance, input ready);
    modport sink   (input valid, encoder_count, elapsed_ticks, distance, output ready);
endinterface

interface mspid_out_if;
    import mspid_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] drive_power;
    logic               clockwise;
    logic               stop_latched;

    modport source (output valid, drive_power, clockwise, stop_latched, input ready);
    modport sink   (input valid, drive_power, clockwise, stop_latched, output ready);
endinterface

`default_nettype wire

// ----- src/mspid_ser_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Unsigned operands; standalone, no package needed.
`default_nettype none

module mspid_ser_mul #(
    parameter int A_W = 16,
    parameter int B_W = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [A_W-1:0]     i_a,
    input  wire logic [B_W-1:0]     i_b,
    output logic                    o_done,
    output logic [A_W+B_W-1:0]      o_prod
);
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]     r_a;
    logic [A_W+B_W-1:0] r_prod;
    logic [A_W+B_W-1:0] n_prod;
    logic [A_W:0]       w_add;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    // Upper half adds the multiplicand when the low bit is set, then all shifts right
    always_comb begin
        w_add  = {1'b0, r_prod[A_W+B_W-1:B_W]} + (r_prod[0] ? {1'b0, r_a} : '0);
        n_prod = {w_add, r_prod[B_W-1:1]};
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and product shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_prod <= {{A_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_prod <= n_prod;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- src/mspid_ser_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned, truncating.
// Standalone, no package needed.
`default_nettype none

module mspid_ser_div #(
    parameter int N_W = 25,
    parameter int D_W = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_dividend,
    input  wire logic [D_W-1:0] i_divisor,
    output logic                o_done,
    output logic [N_W-1:0]      o_quot
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   n_rem;
    logic [N_W-1:0]   r_quo;
    logic [N_W-1:0]   n_quo;
    logic [D_W-1:0]   r_div;
    logic [D_W:0]     w_shift;
    logic [D_W+1:0]   w_diff;
    logic             w_ge;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    // Bring down the next dividend bit and try the subtract
    always_comb begin
        w_shift = {r_rem, r_quo[N_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_div};
        w_ge    = !w_diff[D_W+1];
        n_rem   = w_ge ? w_diff[D_W-1:0] : w_shift[D_W-1:0];
        n_quo   = {r_quo[N_W-2:0], w_ge};
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and dividend/quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// ----- src/motor_speed_pid_with_stop.sv -----
// Motor speed PID with obstacle stop latch: top level, APB register file,
// sequencer and accumulator. Depends on mspid_pkg, mspid_if, mspid_ser_mul, mspid_ser_div.
//
//   channel    dir  transaction                                   accepted when
//   i_item     in   encoder_count, elapsed_ticks, distance        valid && ready
//   o_result   out  drive_power, clockwise, stop_latched          valid && ready
//   APB        in   register write / read (pready tied high)      psel && penable && pwrite
//
// One item at a time: a new item is taken only in the idle state, and the 16-step serial
// gain multipliers and the derivative divider (one quotient bit per cycle) set the time
// that each item takes.
// Synchronous active-low reset loads the register defaults and clears the state.
// A finished result sits in the output register; the next item is taken while it waits,
// and the following result is held back until the slot frees.
`default_nettype none

module motor_speed_pid_with_stop #(
    parameter int GAIN_FRACTION_BITS = mspid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    mspid_in_if.sink                               i_item,
    mspid_out_if.source                            o_result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mspid_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [mspid_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [mspid_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready
);
    import mspid_pkg::*;

    localparam int F         = GAIN_FRACTION_BITS;
    localparam int P_PROD_W  = 2 * FIELD_W;
    localparam int D_PROD_W  = FIELD_W + ERR_W;
    localparam int I1_W      = FIELD_W + ERR_W;
    localparam int I_PROD_W  = I1_W + FIELD_W;
    localparam int DIVN_W    = D_PROD_W - F;
    localparam int SUM_W     = I_PROD_W + 2;

    // ------------------------------------------------------------------
    // Register file
    logic [FIELD_W-1:0] r_cfg [CFG_NUM];
    t_cfg_idx           w_cfg_idx;
    logic               w_cfg_wr;

    assign w_cfg_idx = t_cfg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_cfg_wr  = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = {{(APB_DATA_W-FIELD_W){1'b0}}, r_cfg[w_cfg_idx]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_NUM; k++) begin
                r_cfg[k] <= cfg_reset(t_cfg_idx'(CFG_IDX_W'(k)));
            end
        end else if (w_cfg_wr) begin
            r_cfg[w_cfg_idx] <= pwdata[FIELD_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Declarations
    t_state             r_state, n_state;
    t_term              r_term;
    logic               w_in_acc;
    logic               w_slot;
    logic               w_load;
    logic               w_start1, w_start2;

    logic [FIELD_W-1:0] r_count, r_dt, r_dist;
    logic [FIELD_W-1:0] r_kept;
    logic [ERR_W-1:0]   r_prev;
    logic               r_stop_flag;

    logic [FIELD_W-1:0] w_target;
    logic [ERR_W-1:0]   w_e, w_eabs;
    logic [ERR_W:0]     w_d, w_s, w_dabs, w_sabs;
    logic               w_hit;
    logic [ERR_W-1:0]   r_e;
    logic               r_neg_e, r_neg_d, r_neg_s, r_hit;
    logic [FIELD_W-1:0] r_base;

    logic               r_mul2_ok, r_div_ok;
    logic               w_mul2_ok, w_div_ok;
    logic [SUM_W-1:0]   r_acc, n_acc;
    logic [SUM_W-1:0]   w_tmag;
    logic               w_tneg;
    logic [SUM_W-1:0]   r_mag;
    logic               r_cw;
    logic [SUM_W-1:0]   w_lo, w_hi;
    logic [FIELD_W-1:0] w_power;

    logic               r_out_valid;
    logic [FIELD_W-1:0] r_out_power;
    logic               r_out_cw, r_out_stop;

    logic [P_PROD_W-1:0] w_p_prod;
    logic [D_PROD_W-1:0] w_d_prod;
    logic [I_PROD_W-1:0] w_i_prod;
    logic [DIVN_W-1:0]   w_quot;
    logic                w_p_done, w_d_done, w_i_done, w_div_done;
    logic [I1_W-1:0]     w_i_a;
    logic [FIELD_W-1:0]  w_i_b;

    // ------------------------------------------------------------------
    // Error terms and stop band check, from the captured item
    always_comb begin
        w_target = r_stop_flag ? '0 : r_cfg[CFG_TARGET];
        w_e      = {w_target[FIELD_W-1], w_target} - {r_count[FIELD_W-1], r_count};
        w_d      = {w_e[ERR_W-1], w_e} - {r_prev[ERR_W-1], r_prev};
        w_s      = {w_e[ERR_W-1], w_e} + {r_prev[ERR_W-1], r_prev};
        w_eabs   = w_e[ERR_W-1] ? (ERR_W'(0) - w_e) : w_e;
        w_dabs   = w_d[ERR_W] ? ((ERR_W+1)'(0) - w_d) : w_d;
        w_sabs   = w_s[ERR_W] ? ((ERR_W+1)'(0) - w_s) : w_s;
        w_hit    = (r_dist != '0) &&
                   (({1'b0, r_dist} + (FIELD_W+1)'(STOP_BAND_HALF)) <= {1'b0, r_cfg[CFG_STOP]});
    end

    // ------------------------------------------------------------------
    // Serial arithmetic units
    assign w_i_a = (r_state == ST_MUL) ? w_i_prod[I1_W-1:0]
                                       : {{(I1_W-ERR_W){1'b0}}, w_sabs[ERR_W-1:0]};
    assign w_i_b = (r_state == ST_MUL) ? r_dt : r_cfg[CFG_KI];

    mspid_ser_mul #(.A_W(FIELD_W), .B_W(FIELD_W)) u_mul_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start1),
        .i_a     (w_eabs[FIELD_W-1:0]),
        .i_b     (r_cfg[CFG_KP]),
        .o_done  (w_p_done),
        .o_prod  (w_p_prod)
    );

    mspid_ser_mul #(.A_W(ERR_W), .B_W(FIELD_W)) u_mul_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start1),
        .i_a     (w_dabs[ERR_W-1:0]),
        .i_b     (r_cfg[CFG_KD]),
        .o_done  (w_d_done),
        .o_prod  (w_d_prod)
    );

    // Integral: Ki*|e+last| first, then times dt
    mspid_ser_mul #(.A_W(I1_W), .B_W(FIELD_W)) u_mul_i (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start1 || w_start2),
        .i_a     (w_i_a),
        .i_b     (w_i_b),
        .o_done  (w_i_done),
        .o_prod  (w_i_prod)
    );

    mspid_ser_div #(.N_W(DIVN_W), .D_W(FIELD_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start2),
        .i_dividend (w_d_prod[D_PROD_W-1:F]),
        .i_divisor  (r_dt),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer
    assign w_in_acc  = i_item.valid && i_item.ready;
    assign w_slot    = !r_out_valid || o_result.ready;
    assign w_mul2_ok = r_mul2_ok || w_i_done;
    assign w_div_ok  = r_div_ok || w_div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        i_item.ready = 1'b0;
        w_start1     = 1'b0;
        w_start2     = 1'b0;
        w_load       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_item.ready = 1'b1;
                if (i_item.valid) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                w_start1 = 1'b1;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                if (w_i_done) begin
                    w_start2 = 1'b1;
                    n_state  = ST_MUL2DIV;
                end
            end
            ST_MUL2DIV: begin
                if (w_mul2_ok && w_div_ok) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (r_term == TERM_I) begin
                    n_state = ST_ABS;
                end
            end
            ST_ABS: begin
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                if (w_slot) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Completion flags for the second arithmetic pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul2_ok <= 1'b0;
            r_div_ok  <= 1'b0;
        end else if (w_start2) begin
            r_mul2_ok <= 1'b0;
            r_div_ok  <= 1'b0;
        end else begin
            r_mul2_ok <= w_mul2_ok;
            r_div_ok  <= w_div_ok;
        end
    end

    // ------------------------------------------------------------------
    // Item capture and per-item signs
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_count <= i_item.encoder_count;
            r_dt    <= (i_item.elapsed_ticks == '0) ? FIELD_W'(1) : i_item.elapsed_ticks;
            r_dist  <= i_item.distance;
        end
        if (r_state == ST_PREP) begin
            r_e     <= w_e;
            r_neg_e <= w_e[ERR_W-1];
            r_neg_d <= w_d[ERR_W];
            r_neg_s <= w_s[ERR_W];
            r_hit   <= w_hit;
            r_base  <= w_hit ? '0 : r_kept;
        end
    end

    // ------------------------------------------------------------------
    // Accumulate base + P + D + I, one signed term per cycle
    always_comb begin
        case (r_term)
            TERM_P: begin
                w_tmag = SUM_W'(w_p_prod >> F);
                w_tneg = r_neg_e;
            end
            TERM_D: begin
                w_tmag = SUM_W'(w_quot);
                w_tneg = r_neg_d;
            end
            TERM_I: begin
                w_tmag = SUM_W'(w_i_prod >> (F + 1));
                w_tneg = r_neg_s;
            end
            default: begin
                w_tmag = '0;
                w_tneg = 1'b0;
            end
        endcase
        n_acc = r_acc + (w_tneg ? ~w_tmag : w_tmag) + SUM_W'(w_tneg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term <= TERM_P;
        end else if (r_state == ST_SUM) begin
            case (r_term)
                TERM_P:  r_term <= TERM_D;
                TERM_D:  r_term <= TERM_I;
                default: r_term <= TERM_P;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL2DIV) begin
            r_acc <= SUM_W'(r_base);
        end else if (r_state == ST_SUM) begin
            r_acc <= n_acc;
        end
        if (r_state == ST_ABS) begin
            r_cw  <= !r_acc[SUM_W-1];
            r_mag <= r_acc[SUM_W-1] ? (SUM_W'(0) - r_acc) : r_acc;
        end
    end

    // ------------------------------------------------------------------
    // Clamp: minimum first, maximum second
    always_comb begin
        w_lo    = (r_mag < SUM_W'(r_cfg[CFG_PMIN])) ? SUM_W'(r_cfg[CFG_PMIN]) : r_mag;
        w_hi    = (w_lo > SUM_W'(r_cfg[CFG_PMAX])) ? SUM_W'(r_cfg[CFG_PMAX]) : w_lo;
        w_power = w_hi[FIELD_W-1:0];
    end

    // Controller state, updated when the result is handed to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept      <= cfg_reset(CFG_START);
            r_prev      <= '0;
            r_stop_flag <= 1'b0;
        end else if (w_load) begin
            r_kept      <= w_power;
            r_prev      <= r_e;
            r_stop_flag <= r_stop_flag || r_hit;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_power <= w_power;
            r_out_cw    <= r_cw;
            r_out_stop  <= r_stop_flag || r_hit;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.drive_power  = r_out_power;
    assign o_result.clockwise    = r_out_cw;
    assign o_result.stop_latched = r_out_stop;

    // ------------------------------------------------------------------
    // Checks
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_MUL2DIV))
        else $error("divider finished outside the second arithmetic pass");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_i_done |-> (r_state == ST_MUL || r_state == ST_MUL2DIV))
        else $error("integral multiplier finished outside an arithmetic pass");

    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_p_done == w_d_done)
        else $error("proportional and derivative multipliers out of step");

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop_flag |=> r_stop_flag)
        else $error("stop latch cleared without reset");

    a_power_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_out_power <= r_cfg[CFG_PMAX]))
        else $error("drive power above the configured maximum");

endmodule

`default_nettype wire

// ----- tb/tb_motor_speed_pid_with_stop.sv -----
// Self-checking testbench for motor_speed_pid_with_stop: directed table, then random
// sensor transactions under three idle mixes, checked against a behavioral PID model
// or hand-typed commands. Depends on mspid_pkg, mspid_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_motor_speed_pid_with_stop;
    import mspid_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 200;
    localparam int NUM_ROWS    = 28;

    typedef struct packed {
        logic signed [FIELD_W-1:0] count;
        logic        [FIELD_W-1:0] ticks;
        logic        [FIELD_W-1:0] obst;
    } t_sensor;

    typedef struct packed {
        logic [FIELD_W-1:0] power;
        logic               cw;
        logic               stopped;
    } t_drive;

    // One directed row: optional register write before it, the sensor transaction and,
    // where obvious, the drive command typed in by hand
    typedef struct packed {
        bit                        late;
        bit                        wr;
        t_cfg_idx                  idx;
        logic        [FIELD_W-1:0] val;
        logic signed [FIELD_W-1:0] count;
        logic        [FIELD_W-1:0] ticks;
        logic        [FIELD_W-1:0] obst;
        bit                        fixed;
        logic        [FIELD_W-1:0] power;
        bit                        cw;
        bit                        stopped;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mspid_in_if  sens_if ();
    mspid_out_if drv_if ();

    motor_speed_pid_with_stop u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (sens_if),
        .o_result (drv_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Model copy of the register file
    logic        [FIELD_W-1:0] cfg_kp     = 16'd256;
    logic        [FIELD_W-1:0] cfg_ki     = 16'd0;
    logic        [FIELD_W-1:0] cfg_kd     = 16'd0;
    logic        [FIELD_W-1:0] cfg_pmin   = 16'd0;
    logic        [FIELD_W-1:0] cfg_pmax   = 16'd1000;
    logic signed [FIELD_W-1:0] cfg_target = 16'sd0;
    logic        [FIELD_W-1:0] cfg_start  = 16'd0;
    logic        [FIELD_W-1:0] cfg_stop   = 16'd300;

    // Model controller state
    logic [FIELD_W-1:0] kept_power = 16'd0;
    longint             last_err   = 0;
    bit                 stop_seen  = 1'b0;

    t_drive    pending_drive_q [$];
    t_stim_row dir_rows [0:NUM_ROWS-1];
    int        mismatch_cnt  = 0;
    int        cycle_cnt     = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    // Clock, 12 ns period
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Incremental PID step; updates the model state and returns the drive command
    function automatic t_drive pid_next_drive(input t_sensor s);
        longint dt, tgt, err, base, acc, mag, band_top, obst, one;
        t_drive d;
        one  = longint'(1) << GAIN_FRAC_BITS_DEF;
        dt   = longint'(s.ticks);
        obst = longint'(s.obst);
        if (dt == 0) dt = 1;
        if (stop_seen) tgt = 0;
        else tgt = longint'($signed(cfg_target));
        err = tgt - longint'($signed(s.count));

        // stop band zeroes the base and sets the latch
        band_top = longint'(cfg_stop) - STOP_BAND_HALF;
        base     = longint'(kept_power);
        if (obst > 0 && obst <= band_top) begin
            base      = 0;
            stop_seen = 1'b1;
        end

        acc = base;
        acc = acc + (longint'(cfg_kp) * err) / one;
        acc = acc + (longint'(cfg_kd) * (err - last_err)) / (dt * one);
        acc = acc + (longint'(cfg_ki) * (err + last_err) * dt) / (2 * one);

        // min first, max second: crossed bounds give power_max
        d.cw = (acc >= 0);
        mag  = d.cw ? acc : -acc;
        if (mag < longint'(cfg_pmin)) mag = longint'(cfg_pmin);
        if (mag > longint'(cfg_pmax)) mag = longint'(cfg_pmax);

        kept_power = mag[FIELD_W-1:0];
        last_err   = err;
        d.power    = kept_power;
        d.stopped  = stop_seen;
        return d;
    endfunction

    // APB write: setup then access; also updates the model registers
    task automatic cfg_write(input t_cfg_idx idx, input logic [FIELD_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DATA_W-FIELD_W){1'b0}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_KP:     cfg_kp     = val;
            CFG_KI:     cfg_ki     = val;
            CFG_KD:     cfg_kd     = val;
            CFG_PMIN:   cfg_pmin   = val;
            CFG_PMAX:   cfg_pmax   = val;
            CFG_TARGET: cfg_target = val;
            CFG_START:  cfg_start  = val;   // kept power never takes it; reset loads the default
            CFG_STOP:   cfg_stop   = val;
            default: ;
        endcase
    endtask

    // Drop valid and wait until every drive command has come back
    task automatic wait_drained();
        sens_if.valid <= 1'b0;
        while (pending_drive_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Offer one sensor transaction, with random gaps, and queue its drive command
    task automatic send_sensor(input t_sensor s, input bit use_fixed, input t_drive fixed);
        t_drive d;
        while ($urandom_range(99) < send_idle_pct) begin
            sens_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        sens_if.valid         <= 1'b1;
        sens_if.encoder_count <= s.count;
        sens_if.elapsed_ticks <= s.ticks;
        sens_if.distance      <= s.obst;
        @(posedge i_clk);
        while (!sens_if.ready) @(posedge i_clk);
        d = pid_next_drive(s);
        pending_drive_q.push_back(use_fixed ? fixed : d);
    endtask

    // Walk the directed table; late rows latch the stop and so run last
    task automatic walk_rows(input bit late_pass);
        t_sensor s;
        t_drive  want;
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (dir_rows[i].late == late_pass) begin
                if (dir_rows[i].wr) begin
                    wait_drained();
                    cfg_write(dir_rows[i].idx, dir_rows[i].val);
                end
                s.count      = dir_rows[i].count;
                s.ticks      = dir_rows[i].ticks;
                s.obst       = dir_rows[i].obst;
                want.power   = dir_rows[i].power;
                want.cw      = dir_rows[i].cw;
                want.stopped = dir_rows[i].stopped;
                send_sensor(s, dir_rows[i].fixed, want);
            end
        end
    endtask

    function automatic logic [FIELD_W-1:0] rand_gain();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 600));
        endcase
    endfunction

    // New random setting of all registers, extremes included
    task automatic new_setting(input bit allow_band);
        logic [FIELD_W-1:0] v;
        cfg_write(CFG_KP, rand_gain());
        cfg_write(CFG_KI, rand_gain());
        cfg_write(CFG_KD, rand_gain());
        case ($urandom_range(4))
            0:       v = 16'd0;
            1:       v = 16'hFFFF;
            2:       v = 16'($urandom_range(0, 300));
            default: v = 16'($urandom_range(0, 2000));
        endcase
        cfg_write(CFG_PMIN, v);
        case ($urandom_range(4))
            0:       v = 16'hFFFF;
            1:       v = 16'd0;
            2:       v = 16'($urandom_range(0, 300));    // often crossed with min
            default: v = 16'($urandom_range(500, 65535));
        endcase
        cfg_write(CFG_PMAX, v);
        case ($urandom_range(4))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2:       v = 16'($urandom_range(0, 400) - 200);
            default: v = 16'($urandom);
        endcase
        cfg_write(CFG_TARGET, v);
        cfg_write(CFG_START, 16'($urandom));
        if (allow_band) begin
            case ($urandom_range(3))
                0:       v = 16'd50;
                1:       v = 16'hFFFF;
                default: v = 16'($urandom_range(51, 3000));
            endcase
        end else begin
            case ($urandom_range(4))
                0, 1:    v = 16'd50;                       // empty band
                2:       v = 16'($urandom_range(51, 2000));
                3:       v = 16'hFFFF;
                default: v = 16'($urandom_range(50, 65535));
            endcase
        end
        cfg_write(CFG_STOP, v);
    endtask

    // Random sensor transactions over several settings
    task automatic run_random(input int n_set, input int n_items, input bit allow_band);
        t_sensor                   s;
        t_drive                    none;
        logic signed [FIELD_W-1:0] near;
        int                        band_top;
        none = '0;
        for (int k = 0; k < n_set; k++) begin
            wait_drained();
            new_setting(allow_band);
            for (int n = 0; n < n_items; n++) begin
                near = stop_seen ? 16'sd0 : cfg_target;
                if ($urandom_range(1) == 0) s.count = near - 16'sd64 + 16'($urandom_range(0, 128));
                else s.count = 16'($urandom);
                case ($urandom_range(9))
                    0, 1, 2: s.ticks = 16'($urandom_range(0, 4));
                    3, 4, 5: s.ticks = 16'($urandom);
                    default: s.ticks = 16'($urandom_range(1, 100));
                endcase
                band_top = int'(cfg_stop) - STOP_BAND_HALF;
                if (band_top <= 0) begin
                    s.obst = 16'($urandom);
                end else if (!allow_band) begin
                    // keep clear of the band so the latch stays open
                    if ($urandom_range(3) == 0) s.obst = 16'd0;
                    else s.obst = 16'($urandom_range(band_top + 1, 65535));
                end else begin
                    case ($urandom_range(3))
                        0:       s.obst = 16'd0;
                        1:       s.obst = 16'($urandom_range(1, band_top));
                        2:       s.obst = 16'(band_top + $urandom_range(0, 1));
                        default: s.obst = 16'($urandom);
                    endcase
                end
                send_sensor(s, 1'b0, none);
            end
        end
    endtask

    // Drive command checker and receiver stalls
    always @(posedge i_clk) begin : drive_check
        t_drive want;
        if (!i_rst_n) begin
            drv_if.ready <= 1'b0;
        end else begin
            if (drv_if.valid && drv_if.ready) begin
                if (pending_drive_q.size() == 0) begin
                    $error("drive transaction with none expected: power %0d",
                           drv_if.drive_power);
                    mismatch_cnt++;
                end else begin
                    want = pending_drive_q.pop_front();
                    if (drv_if.drive_power !== want.power) begin
                        $error("drive_power: expected %0d, actual %0d",
                               want.power, drv_if.drive_power);
                        mismatch_cnt++;
                    end
                    if (drv_if.clockwise !== want.cw) begin
                        $error("clockwise: expected %0d, actual %0d",
                               want.cw, drv_if.clockwise);
                        mismatch_cnt++;
                    end
                    if (drv_if.stop_latched !== want.stopped) begin
                        $error("stop_latched: expected %0d, actual %0d",
                               want.stopped, drv_if.stop_latched);
                        mismatch_cnt++;
                    end
                end
            end
            drv_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        i_rst_n               <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        sens_if.valid         <= 1'b0;
        sens_if.encoder_count <= '0;
        sens_if.elapsed_ticks <= '0;
        sens_if.distance      <= '0;

        // late wr idx val count ticks obst | fixed power cw stop
        // after reset: defaults, kept power 0
        dir_rows[0]  = '{0, 0, CFG_KP, 16'd0, 16'sd0, 16'd0, 16'd0, 1, 16'd0, 1, 0};
        dir_rows[1]  = '{0, 0, CFG_KP, 16'd0, -16'sd100, 16'd1, 16'd0, 1, 16'd100, 1, 0};
        dir_rows[2]  = '{0, 0, CFG_KP, 16'd0, 16'sd100, 16'd2, 16'd0, 1, 16'd0, 1, 0};
        // count extremes saturate at power_max
        dir_rows[3]  = '{0, 0, CFG_KP, 16'd0, 16'sh7FFF, 16'd0, 16'd0, 1, 16'd1000, 0, 0};
        dir_rows[4]  = '{0, 0, CFG_KP, 16'd0, 16'sh8000, 16'hFFFF, 16'd0, 1, 16'd1000, 1, 0};
        // just above the band, and the far end
        dir_rows[5]  = '{0, 0, CFG_KP, 16'd0, 16'sd1, 16'd1, 16'd251, 1, 16'd999, 1, 0};
        dir_rows[6]  = '{0, 0, CFG_KP, 16'd0, 16'sd0, 16'hFFFF, 16'hFFFF, 1, 16'd999, 1, 0};
        // crossed bounds
        dir_rows[7]  = '{0, 1, CFG_PMIN, 16'd2000, 16'sd0, 16'd1, 16'd0, 1, 16'd1000, 1, 0};
        dir_rows[8]  = '{0, 1, CFG_PMIN, 16'd0, 16'sd0, 16'd1, 16'd0, 1, 16'd1000, 1, 0};
        // stop distance at or under the half band: empty band
        dir_rows[9]  = '{0, 1, CFG_STOP, 16'd49, 16'sd0, 16'd1, 16'd1, 1, 16'd1000, 1, 0};
        dir_rows[10] = '{0, 1, CFG_STOP, 16'd50, 16'sd0, 16'd1, 16'd1, 1, 16'd1000, 1, 0};
        dir_rows[11] = '{0, 1, CFG_STOP, 16'd300, 16'sd0, 16'd1, 16'd300, 1, 16'd1000, 1, 0};
        // gain and target extremes
        dir_rows[12] = '{0, 1, CFG_KD, 16'hFFFF, 16'sh8000, 16'd0, 16'd0, 0, 16'd0, 0, 0};
        dir_rows[13] = '{0, 0, CFG_KP, 16'd0, 16'sh7FFF, 16'd1, 16'd0, 0, 16'd0, 0, 0};
        dir_rows[14] = '{0, 0, CFG_KP, 16'd0, 16'sd0, 16'hFFFF, 16'd0, 0, 16'd0, 0, 0};
        dir_rows[15] = '{0, 1, CFG_KI, 16'hFFFF, 16'sh8000, 16'hFFFF, 16'd0, 0, 16'd0, 0, 0};
        dir_rows[16] = '{0, 0, CFG_KP, 16'd0, 16'sh7FFF, 16'hFFFF, 16'd0, 0, 16'd0, 0, 0};
        dir_rows[17] = '{0, 1, CFG_KP, 16'hFFFF, 16'sd12345, 16'd3, 16'd0, 0, 16'd0, 0, 0};
        dir_rows[18] = '{0, 1, CFG_PMAX, 16'hFFFF, 16'sh8000, 16'hFFFF, 16'd0, 0, 16'd0, 0, 0};
        dir_rows[19] = '{0, 1, CFG_TARGET, 16'h7FFF, 16'sh8000, 16'd7, 16'd0, 0, 16'd0, 0, 0};
        dir_rows[20] = '{0, 1, CFG_TARGET, 16'h8000, 16'sh7FFF, 16'd0, 16'd0, 0, 16'd0, 0, 0};
        dir_rows[21] = '{0, 1, CFG_PMIN, 16'hFFFF, 16'sd0, 16'd1, 16'd0, 0, 16'd0, 0, 0};
        dir_rows[22] = '{0, 1, CFG_START, 16'hFFFF, 16'sd0, 16'd1, 16'd0, 0, 16'd0, 0, 0};
        dir_rows[23] = '{0, 1, CFG_KP, 16'd0, -16'sd1, 16'd2, 16'd0, 0, 16'd0, 0, 0};
        // stop band entry: target still applies on the entry step, zero after
        dir_rows[24] = '{1, 0, CFG_KP, 16'd0, 16'sd1000, 16'd1, 16'd251, 0, 16'd0, 0, 0};
        dir_rows[25] = '{1, 0, CFG_KP, 16'd0, 16'sd0, 16'd1, 16'd250, 1, 16'd1000, 1, 1};
        dir_rows[26] = '{1, 0, CFG_KP, 16'd0, 16'sd0, 16'd1, 16'd0, 1, 16'd1000, 1, 1};
        dir_rows[27] = '{1, 0, CFG_KP, 16'd0, 16'sd5, 16'd1, 16'd0, 1, 16'd995, 1, 1};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles more rarely than the receiver
        send_idle_pct = 38;
        recv_idle_pct = 57;
        walk_rows(1'b0);
        run_random(5, 130, 1'b0);

        // the other way round
        send_idle_pct = 57;
        recv_idle_pct = 38;
        run_random(5, 130, 1'b0);

        // no idling; latch the stop, then random with the band open
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_drained();
        cfg_write(CFG_KP, 16'd256);
        cfg_write(CFG_KI, 16'd0);
        cfg_write(CFG_KD, 16'd0);
        cfg_write(CFG_PMIN, 16'd0);
        cfg_write(CFG_PMAX, 16'd1000);
        cfg_write(CFG_TARGET, 16'd1000);
        cfg_write(CFG_STOP, 16'd300);
        walk_rows(1'b1);
        run_random(5, 130, 1'b1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_drive_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
